>>> rtl/alwt_pkg.sv
package alwt_pkg;

   localparam int POS_WIDTH  = 16;
   localparam int MAX_LEN    = 65535;
   localparam int NUM_STATES = 10;
   localparam int NUM_CLASSES = 9;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
   localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

   localparam logic [POS_WIDTH-1:0] POS_MAX = POS_WIDTH'(MAX_LEN);

   typedef logic [POS_WIDTH-1:0] pos_type;

   typedef enum logic [3:0] {
      CL_OTHER = 4'd0,
      CL_SPACE = 4'd1,
      CL_LETTER = 4'd2,
      CL_N = 4'd3,
      CL_B = 4'd4,
      CL_DIGIT = 4'd5,
      CL_DOT = 4'd6,
      CL_COLON = 4'd7,
      CL_QUOTE = 4'd8
   } class_type;

   typedef enum logic [3:0] {
      S_SPACE = 4'd0,
      S_OTHER = 4'd1,
      S_NAME = 4'd2,
      S_N = 4'd3,
      S_NB = 4'd4,
      S_NBDOT = 4'd5,
      S_NUM = 4'd6,
      S_QUOTE = 4'd7,
      S_QCLOSE = 4'd8,
      S_COMMENT = 4'd9
   } scan_state_type;

   typedef enum logic [2:0] {
      FX_NONE = 3'd0,
      FX_BEGIN = 3'd1,
      FX_WORD = 3'd2,
      FX_WORD_GAP = 3'd3,
      FX_VEC = 3'd4,
      FX_VEC_GAP = 3'd5
   } effect_type;

   // one queued character: clamped class, restart flag, its position
   typedef struct packed {
      class_type cls;
      logic      restart;
      pos_type   pos;
   } entry_type;

   localparam scan_state_type NEXT_TAB [NUM_STATES][NUM_CLASSES] = '{
      '{S_OTHER, S_SPACE, S_NAME, S_N, S_NAME, S_NUM, S_OTHER, S_OTHER, S_QUOTE},
      '{S_OTHER, S_SPACE, S_NAME, S_N, S_NAME, S_NUM, S_OTHER, S_OTHER, S_QUOTE},
      '{S_OTHER, S_SPACE, S_NAME, S_NAME, S_NAME, S_NAME, S_OTHER, S_OTHER, S_QUOTE},
      '{S_OTHER, S_SPACE, S_NAME, S_NAME, S_NB, S_NAME, S_OTHER, S_OTHER, S_QUOTE},
      '{S_OTHER, S_SPACE, S_NAME, S_NAME, S_NAME, S_NAME, S_NBDOT, S_OTHER, S_QUOTE},
      '{S_COMMENT, S_COMMENT, S_COMMENT, S_COMMENT, S_COMMENT, S_COMMENT,
        S_OTHER, S_OTHER, S_COMMENT},
      '{S_OTHER, S_SPACE, S_NUM, S_NUM, S_NUM, S_NUM, S_NUM, S_OTHER, S_QUOTE},
      '{S_QUOTE, S_QUOTE, S_QUOTE, S_QUOTE, S_QUOTE, S_QUOTE, S_QUOTE, S_QUOTE,
        S_QCLOSE},
      '{S_OTHER, S_SPACE, S_NAME, S_N, S_NAME, S_NUM, S_OTHER, S_OTHER, S_QUOTE},
      '{S_COMMENT, S_COMMENT, S_COMMENT, S_COMMENT, S_COMMENT, S_COMMENT,
        S_COMMENT, S_COMMENT, S_COMMENT}
   };

   localparam effect_type FX_TAB [NUM_STATES][NUM_CLASSES] = '{
      '{FX_BEGIN, FX_NONE, FX_BEGIN, FX_BEGIN, FX_BEGIN, FX_BEGIN, FX_BEGIN,
        FX_BEGIN, FX_BEGIN},
      '{FX_WORD, FX_WORD_GAP, FX_WORD, FX_WORD, FX_WORD, FX_WORD, FX_NONE,
        FX_NONE, FX_WORD},
      '{FX_WORD, FX_WORD_GAP, FX_NONE, FX_NONE, FX_NONE, FX_NONE, FX_NONE,
        FX_NONE, FX_WORD},
      '{FX_WORD, FX_WORD_GAP, FX_NONE, FX_NONE, FX_NONE, FX_NONE, FX_NONE,
        FX_NONE, FX_WORD},
      '{FX_WORD, FX_WORD_GAP, FX_NONE, FX_NONE, FX_NONE, FX_NONE, FX_NONE,
        FX_NONE, FX_WORD},
      '{FX_NONE, FX_NONE, FX_NONE, FX_NONE, FX_NONE, FX_NONE, FX_NONE,
        FX_NONE, FX_NONE},
      '{FX_VEC, FX_VEC_GAP, FX_NONE, FX_NONE, FX_NONE, FX_NONE, FX_NONE,
        FX_NONE, FX_VEC},
      '{FX_NONE, FX_NONE, FX_NONE, FX_NONE, FX_NONE, FX_NONE, FX_NONE,
        FX_NONE, FX_NONE},
      '{FX_WORD, FX_WORD_GAP, FX_WORD, FX_WORD, FX_WORD, FX_WORD, FX_WORD,
        FX_WORD, FX_NONE},
      '{FX_NONE, FX_NONE, FX_NONE, FX_NONE, FX_NONE, FX_NONE, FX_NONE,
        FX_NONE, FX_NONE}
   };

endpackage

>>> rtl/alwt_front.sv
module alwt_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,
   input  logic                req_tuser,
   input  logic                q_full,
   output logic                push,
   output alwt_pkg::entry_type push_entry
);
   import alwt_pkg::*;

   pos_type pos_ff;
   pos_type pos_in;
   pos_type item_pos;
   class_type cls;

   assign req_tready = !q_full;
   assign push       = req_tvalid && !q_full;

   // codes past quote count as other
   always_comb begin
      if (req_tdata[3:0] > CL_QUOTE) begin
         cls = CL_OTHER;
      end else begin
         cls = class_type'(req_tdata[3:0]);
      end
   end

   assign item_pos = req_tuser ? '0 : pos_ff;

   always_comb begin
      pos_in = pos_ff;
      if (push) begin
         pos_in = (item_pos < POS_MAX) ? item_pos + POS_WIDTH'(1) : POS_MAX;
      end
   end

   assign push_entry = '{cls: cls, restart: req_tuser, pos: item_pos};

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

>>> rtl/alwt_queue.sv
module alwt_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  alwt_pkg::entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output logic                pop_valid,
   output alwt_pkg::entry_type pop_entry
);
   import alwt_pkg::*;

   entry_type mem [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_WIDTH-1:0] count_ff, count_in;
   logic do_pop;

   assign full      = (count_ff == QCNT_WIDTH'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_entry = mem[rd_ptr_ff];
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0
                   : wr_ptr_ff + QPTR_WIDTH'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0
                   : rd_ptr_ff + QPTR_WIDTH'(1);
      end
      if (push && !do_pop) begin
         count_in = count_ff + QCNT_WIDTH'(1);
      end else if (!push && do_pop) begin
         count_in = count_ff - QCNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_WIDTH'(QUEUE_DEPTH))
      else $error("queue count past depth");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("push into full queue");
   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("empty queue with unequal pointers");
`endif

endmodule

>>> rtl/alwt_back.sv
module alwt_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  alwt_pkg::entry_type q_entry,
   output logic                q_pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [31:0]         rsp_tdata
);
   import alwt_pkg::*;

   scan_state_type state_ff, state_in;
   pos_type ws_ff, ws_in;
   logic    wsv_ff, wsv_in;
   logic    vo_ff, vo_in;
   pos_type vs_ff, vs_in;
   pos_type vl_ff, vl_in;
   logic    rsp_valid_ff, rsp_valid_in;
   pos_type rsp_start_ff, rsp_start_in;
   pos_type rsp_len_ff, rsp_len_in;

   scan_state_type st, ns;
   effect_type fx;
   pos_type ws, vs, pos, start;
   logic    wsv, vo, emit, slot_free;
   pos_type emit_start, emit_len;

   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign q_pop     = q_valid && slot_free;

   always_comb begin
      pos = q_entry.pos;
      ws  = q_entry.restart ? '0 : ws_ff;
      wsv = q_entry.restart ? 1'b0 : wsv_ff;
      vo  = q_entry.restart ? 1'b0 : vo_ff;
      vs  = vs_ff;
      st  = q_entry.restart ? S_SPACE : state_ff;
      if (st > S_COMMENT) begin
         st = S_SPACE;
      end
      ns    = NEXT_TAB[st][q_entry.cls];
      fx    = FX_TAB[st][q_entry.cls];
      start = wsv ? ws : pos;

      ws_in      = ws;
      wsv_in     = wsv;
      vo_in      = vo;
      vs_in      = vs;
      vl_in      = vl_ff;
      emit       = 1'b0;
      emit_start = start;
      emit_len   = pos - start;

      unique case (fx)
         FX_BEGIN: begin
            ws_in  = pos;
            wsv_in = 1'b1;
         end
         FX_WORD, FX_WORD_GAP: begin
            emit   = 1'b1;
            ws_in  = pos;
            wsv_in = (fx == FX_WORD);
         end
         FX_VEC, FX_VEC_GAP: begin
            if (!vo) begin
               vs_in = start;
               vl_in = pos - start;
            end else begin
               vl_in = pos - vs;
            end
            vo_in  = 1'b1;
            ws_in  = pos;
            wsv_in = (fx == FX_VEC);
         end
         default: begin
         end
      endcase

      // a numeric run closes on anything but space or more number
      if (vo_in && ns != S_NUM && ns != S_SPACE) begin
         emit       = 1'b1;
         emit_start = vs_in;
         emit_len   = vl_in;
         vo_in      = 1'b0;
      end
      state_in = ns;

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_start_in = rsp_start_ff;
      rsp_len_in   = rsp_len_ff;
      if (q_pop) begin
         rsp_valid_in = emit;
         if (emit) begin
            rsp_start_in = emit_start;
            rsp_len_in   = emit_len;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SPACE;
         wsv_ff       <= 1'b0;
         vo_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (q_pop) begin
            state_ff <= state_in;
            wsv_ff   <= wsv_in;
            vo_ff    <= vo_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         ws_ff <= ws_in;
         vs_ff <= vs_in;
         vl_ff <= vl_in;
      end
      rsp_start_ff <= rsp_start_in;
      rsp_len_ff   <= rsp_len_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_len_ff, rsp_start_ff};

`ifndef SYNTHESIS
   a_vec_state: assert property (@(posedge clock) disable iff (reset)
      vo_ff |-> (state_ff == S_SPACE || state_ff == S_NUM))
      else $error("open vector outside space or number state");
   a_space_nostart: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SPACE) |-> !wsv_ff)
      else $error("word start held in space state");
   a_quote_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_QUOTE || state_ff == S_COMMENT) |-> wsv_ff)
      else $error("quote or comment without word start");
   a_no_pop_stalled: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !q_pop)
      else $error("step taken while result stalled");
`endif

endmodule

>>> rtl/array_language_word_tokenizer.sv
// Word-formation scanner for array-language source text. Each input word is the
// class of one character (tdata[3:0]; codes above quote count as other) and a
// restart flag in tuser that resets the scanner before that character. A result
// word gives the start position and length of a completed token; runs of numbers
// separated by spaces come out as one token, a comment swallows the rest, and a
// token still open at the end of a line is never reported. Positions saturate
// at 65535. Throughput is one character per cycle while rsp takes results, set
// by the table step in the back end; a four-entry queue separates the front end
// from the back end, and a result is registered on rsp after its character has
// left the queue. rsp back-pressure stalls the back end first; req_tready drops
// only once the four-entry queue has filled behind the held result.
module array_language_word_tokenizer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [3:0] char_class, [7:4] zero
   input  logic        req_tuser,    // [0] first_char
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata     // [15:0] token_start, [31:16] token_length
);
   import alwt_pkg::*;

   logic      push, q_full, q_pop, q_valid;
   entry_type push_entry, q_entry;

   alwt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .push       (push),
      .push_entry (push_entry)
   );

   alwt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_entry  (q_entry)
   );

   alwt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_entry    (q_entry),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

>>> test/tb_array_language_word_tokenizer.sv
`timescale 1ns / 100ps

module tb_array_language_word_tokenizer;
   import alwt_pkg::*;

   localparam int QUIET_LIMIT = 3000;
   localparam int TAIL_CYCLES = 8;
   localparam int HOLD_CYCLES = 300;

   typedef struct {
      pos_type start;
      pos_type length;
   } token_type;

   typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_BEAT} rx_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;     // [3:0] char_class, [7:4] zero
   logic        req_tuser = 1'b0;   // [0] first_char
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;          // [15:0] token_start, [31:16] token_length

   token_type expected_tokens[$];
   int mismatches = 0;
   int quiet_cycles = 0;
   int stall_cycles = 0;
   int burst_left = 0;
   bit steady_flow = 1'b0;

   // scanner shadow state
   scan_state_type scan_st;
   pos_type next_pos, word_begin, vec_begin, vec_len;
   bit word_held, vec_open;

   array_language_word_tokenizer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void clear_scanner();
      scan_st = S_SPACE;
      next_pos = '0;
      word_begin = '0;
      word_held = 1'b0;
      vec_open = 1'b0;
      vec_begin = '0;
      vec_len = '0;
   endfunction

   function automatic scan_state_type next_state(scan_state_type st, class_type c);
      scan_state_type ns;
      bit fresh;
      // states after which a new token may start
      fresh = (st == S_SPACE || st == S_OTHER || st == S_QCLOSE);
      case (st)
         S_QUOTE:   ns = (c == CL_QUOTE) ? S_QCLOSE : S_QUOTE;
         S_COMMENT: ns = S_COMMENT;
         S_NBDOT:   ns = (c == CL_DOT || c == CL_COLON) ? S_OTHER : S_COMMENT;
         S_NUM:
            case (c)
               CL_SPACE:           ns = S_SPACE;
               CL_OTHER, CL_COLON: ns = S_OTHER;
               CL_QUOTE:           ns = S_QUOTE;
               default:            ns = S_NUM;
            endcase
         default:
            case (c)
               CL_OTHER, CL_COLON: ns = S_OTHER;
               CL_DOT:             ns = (st == S_NB) ? S_NBDOT : S_OTHER;
               CL_SPACE:           ns = S_SPACE;
               CL_QUOTE:           ns = S_QUOTE;
               CL_N:               ns = fresh ? S_N : S_NAME;
               CL_B:               ns = (st == S_N) ? S_NB : S_NAME;
               CL_DIGIT:           ns = fresh ? S_NUM : S_NAME;
               default:            ns = S_NAME;
            endcase
      endcase
      return ns;
   endfunction

   function automatic effect_type effect_of(scan_state_type st, class_type c);
      effect_type fx;
      case (st)
         S_SPACE: fx = (c == CL_SPACE) ? FX_NONE : FX_BEGIN;
         S_OTHER, S_QCLOSE: begin
            if (c == CL_SPACE)
               fx = FX_WORD_GAP;
            else if (st == S_OTHER && (c == CL_DOT || c == CL_COLON))
               fx = FX_NONE;
            else if (st == S_QCLOSE && c == CL_QUOTE)
               fx = FX_NONE;   // doubled quote stays in the string
            else
               fx = FX_WORD;
         end
         S_NAME, S_N, S_NB: begin
            if (c == CL_SPACE)
               fx = FX_WORD_GAP;
            else if (c == CL_OTHER || c == CL_QUOTE)
               fx = FX_WORD;
            else
               fx = FX_NONE;
         end
         S_NUM: begin
            if (c == CL_SPACE)
               fx = FX_VEC_GAP;
            else if (c == CL_OTHER || c == CL_QUOTE)
               fx = FX_VEC;
            else
               fx = FX_NONE;
         end
         default: fx = FX_NONE;
      endcase
      return fx;
   endfunction

   function automatic void predict_char(logic [3:0] raw, bit restart);
      class_type c;
      scan_state_type ns;
      effect_type fx;
      pos_type pos, start;
      token_type tok;
      bit have_tok;
      if (restart)
         clear_scanner();
      c = (raw >= NUM_CLASSES) ? CL_OTHER : class_type'(raw);
      have_tok = 1'b0;
      pos = next_pos;
      ns = next_state(scan_st, c);
      fx = effect_of(scan_st, c);
      start = word_held ? word_begin : pos;
      case (fx)
         FX_BEGIN: begin
            word_begin = pos;
            word_held = 1'b1;
         end
         FX_WORD, FX_WORD_GAP: begin
            tok.start = start;
            tok.length = pos - start;
            have_tok = 1'b1;
            word_begin = pos;
            word_held = (fx == FX_WORD);
         end
         FX_VEC, FX_VEC_GAP: begin
            if (!vec_open) begin
               vec_begin = start;
               vec_len = pos - start;
            end else begin
               vec_len = pos - vec_begin;
            end
            vec_open = 1'b1;
            word_begin = pos;
            word_held = (fx == FX_VEC);
         end
         default: ;
      endcase
      // a pending vector closes once the scanner leaves number/space
      if (vec_open && ns != S_NUM && ns != S_SPACE) begin
         tok.start = vec_begin;
         tok.length = vec_len;
         have_tok = 1'b1;
         vec_open = 1'b0;
      end
      if (have_tok)
         expected_tokens.push_back(tok);
      scan_st = ns;
      if (pos != POS_MAX)
         next_pos = pos + 1'b1;
   endfunction

   task automatic send_char(logic [3:0] cls, bit first);
      int gap;
      if (!steady_flow && burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 32);
      end
      if (burst_left > 0)
         burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= {4'b0000, cls};
      req_tuser <= first;
      do @(posedge clock); while (!req_tready);
      predict_char(cls, first);
   endtask

   task automatic drain_tokens();
      req_tvalid <= 1'b0;
      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   // never a quote and no B unless asked, so no string can open, nor a comment without B
   function automatic logic [3:0] plain_class(bit allow_b);
      logic [3:0] c;
      do c = 4'($urandom_range(0, 7)); while (!allow_b && c == CL_B);
      return c;
   endfunction

   task automatic test_directed();
      send_char(CL_OTHER, 1'b1);
      send_char(CL_LETTER, 1'b0);
      send_char(CL_SPACE, 1'b0);
      send_char(CL_SPACE, 1'b0);
      send_char(CL_N, 1'b0);
      send_char(CL_LETTER, 1'b0);
      send_char(CL_QUOTE, 1'b0);
      send_char(CL_OTHER, 1'b0);
      send_char(CL_QUOTE, 1'b0);
      send_char(CL_QUOTE, 1'b0);
      send_char(CL_COLON, 1'b0);
      // numbers with spaces merge into one vector
      send_char(CL_DIGIT, 1'b0);
      send_char(CL_SPACE, 1'b0);
      send_char(CL_DIGIT, 1'b0);
      send_char(CL_DOT, 1'b0);
      send_char(CL_SPACE, 1'b0);
      send_char(CL_DIGIT, 1'b0);
      send_char(CL_LETTER, 1'b0);
      send_char(CL_COLON, 1'b0);
      // out-of-range classes, then a comment
      send_char(4'(NUM_CLASSES), 1'b1);
      send_char(4'hF, 1'b0);
      send_char(CL_N, 1'b0);
      send_char(CL_B, 1'b0);
      send_char(CL_DOT, 1'b0);
      send_char(CL_QUOTE, 1'b0);
      drain_tokens();
   endtask

   task automatic test_random_lines(int target);
      logic [3:0] line_q[$];
      int sent, len;
      bit restart;
      sent = 0;
      while (sent < target) begin
         line_q.delete();
         restart = ($urandom_range(0, 9) != 0);
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 30);
         while (line_q.size() < len) begin
            case ($urandom_range(0, 10))
               0, 1, 2: begin
                  line_q.push_back($urandom_range(0, 1) ? CL_LETTER : CL_N);
                  repeat ($urandom_range(0, 5))
                     line_q.push_back(4'(CL_LETTER) + 4'($urandom_range(0, 3)));
               end
               3, 4: begin
                  line_q.push_back(CL_DIGIT);
                  repeat ($urandom_range(0, 3))
                     line_q.push_back(($urandom_range(0, 2) == 0) ? CL_DOT : CL_DIGIT);
                  if ($urandom_range(0, 4) == 0)
                     line_q.push_back(CL_LETTER);
                  if ($urandom_range(0, 1)) begin
                     line_q.push_back(CL_SPACE);
                     line_q.push_back(CL_DIGIT);
                  end
               end
               5: begin
                  line_q.push_back(CL_QUOTE);
                  repeat ($urandom_range(0, 5)) line_q.push_back(plain_class(1'b1));
                  line_q.push_back(CL_QUOTE);
                  if ($urandom_range(0, 3) == 0) begin
                     line_q.push_back(CL_QUOTE);
                     line_q.push_back(CL_LETTER);
                     line_q.push_back(CL_QUOTE);
                  end
               end
               6: begin
                  repeat ($urandom_range(1, 3)) begin
                     case ($urandom_range(0, 2))
                        0:       line_q.push_back(CL_OTHER);
                        1:       line_q.push_back(CL_DOT);
                        default: line_q.push_back(CL_COLON);
                     endcase
                  end
               end
               7: begin
                  line_q.push_back(CL_N);
                  if ($urandom_range(0, 1)) begin
                     line_q.push_back(CL_B);
                     line_q.push_back(CL_DOT);
                     repeat ($urandom_range(0, 6))
                        line_q.push_back(4'($urandom_range(0, NUM_CLASSES - 1)));
                  end else begin
                     // broken comment opener
                     if ($urandom_range(0, 1))
                        line_q.push_back(CL_B);
                     line_q.push_back(4'(CL_OTHER) + 4'($urandom_range(0, 7)));
                  end
               end
               8: begin
                  repeat ($urandom_range(1, 3)) line_q.push_back(4'($urandom_range(0, 15)));
               end
               default: begin
                  repeat ($urandom_range(1, 3)) line_q.push_back(CL_SPACE);
               end
            endcase
            if ($urandom_range(0, 9) < 7)
               line_q.push_back(CL_SPACE);
         end
         foreach (line_q[i])
            send_char(line_q[i], restart && i == 0);
         sent += line_q.size();
         if ($urandom_range(0, 15) == 0)
            drain_tokens();
      end
      drain_tokens();
   endtask

   // receiver holds off while words keep coming, so the input stalls
   task automatic test_output_hold();
      steady_flow = 1'b1;
      stall_cycles = HOLD_CYCLES;
      send_char(CL_LETTER, 1'b1);
      repeat (40) begin
         send_char(CL_SPACE, 1'b0);
         send_char(CL_LETTER, 1'b0);
      end
      steady_flow = 1'b0;
      drain_tokens();
   endtask

   // one long line without gaps, with a long string and a merged number run
   task automatic test_long_line();
      steady_flow = 1'b1;
      send_char(CL_LETTER, 1'b1);
      repeat (20) send_char(plain_class(1'b0), 1'b0);
      send_char(CL_SPACE, 1'b0);
      send_char(CL_QUOTE, 1'b0);
      repeat (50) send_char(plain_class(1'b1), 1'b0);
      send_char(CL_QUOTE, 1'b0);
      send_char(CL_SPACE, 1'b0);
      repeat (4) begin
         send_char(CL_LETTER, 1'b0);
         send_char(CL_SPACE, 1'b0);
      end
      send_char(CL_DIGIT, 1'b0);
      send_char(CL_SPACE, 1'b0);
      send_char(CL_DIGIT, 1'b0);
      send_char(CL_OTHER, 1'b0);
      steady_flow = 1'b0;
      drain_tokens();
   endtask

   initial begin : receiver
      rx_mode_type mode;
      int left;
      mode = RX_OPEN;
      left = 0;
      wait (!reset);
      forever begin
         @(posedge clock);
         if (stall_cycles > 0) begin
            rsp_tready <= 1'b0;
            stall_cycles--;
         end else begin
            if (left == 0) begin
               mode = rx_mode_type'($urandom_range(0, 3));
               left = $urandom_range(8, 100);
            end
            left--;
            case (mode)
               RX_OPEN:   rsp_tready <= 1'b1;
               RX_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
               RX_SPARSE: rsp_tready <= ($urandom_range(0, 4) == 0);
               default:   rsp_tready <= (left % 4 != 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin : token_check
      token_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_tokens.size() == 0) begin
            if (mismatches < 10)
               $display("unexpected token: start %0d length %0d",
                        rsp_tdata[15:0], rsp_tdata[31:16]);
            mismatches++;
         end else begin
            want = expected_tokens.pop_front();
            if (rsp_tdata[15:0] !== want.start || rsp_tdata[31:16] !== want.length) begin
               if (mismatches < 10)
                  $display("token mismatch: start exp %0d got %0d, length exp %0d got %0d",
                           want.start, rsp_tdata[15:0], want.length, rsp_tdata[31:16]);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("array_language_word_tokenizer test failed");
         $finish;
      end
   end

   initial begin
      clear_scanner();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_lines(750);
      test_output_hold();
      test_long_line();
      if (mismatches == 0 && expected_tokens.size() == 0)
         $display("array_language_word_tokenizer test passed");
      else
         $display("array_language_word_tokenizer test failed");
      $finish;
   end

endmodule
